// ===== rtl/core/dalc_pkg.sv =====
// Shared types and constants for the DA-LC response bound block.
package dalc_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned PRI_W = 8;
  localparam int unsigned CFG_W = 5;
  localparam int unsigned BOUND_W = 21;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned LOAD_W = 17;
  localparam logic [CFG_W-1:0] CORES_RESET = 5'd8;
  localparam logic [BOUND_W-1:0] BOUND_MAX = 21'h1FFFFF;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] wcet;
    logic [PRI_W-1:0]    priority_req;
    logic                last_task;
  } dalc_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   task_index;
    logic [BOUND_W-1:0] response_bound;
    logic               meets_deadline;
    logic               last_result;
  } dalc_out_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] wcet;
    logic [PRI_W-1:0]    prio;
  } dalc_task_t;

  typedef struct packed {
    logic clear;
    logic insert;
  } dalc_list_ctl_t;

endpackage

// ===== rtl/core/dalc_div.sv =====
// Shared restoring divider that produces one quotient bit per cycle.
module dalc_div #(
  parameter int unsigned DW = 22
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DW-1:0]                 dividend,
  input  logic [dalc_pkg::PERIOD_W-1:0] divisor,
  output logic                          busy,
  output logic                          done,
  output logic [DW-1:0]                 quotient,
  output logic [dalc_pkg::PERIOD_W-1:0] remainder
);
  import dalc_pkg::*;

  localparam int unsigned CNT_W = $clog2(DW + 1);

  logic [DW-1:0]       quo_r, quo_nxt;
  logic [PERIOD_W-1:0] rem_r, rem_nxt;
  logic [PERIOD_W-1:0] dvs_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   diff;
  logic                fits;

  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    diff = trial - {1'b0, dvs_r};
    fits = trial >= {1'b0, dvs_r};
    rem_nxt = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    quo_nxt = {quo_r[DW-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= CNT_W'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quotient = quo_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/core/dalc_toplist.sv =====
// Sorted list of the largest interference differences with a running sum.
module dalc_toplist #(
  parameter int unsigned DEPTH = 15,
  parameter int unsigned KW = 5,
  parameter int unsigned SUM_W = 21
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dalc_pkg::dalc_list_ctl_t      ctl,
  input  logic [KW-1:0]                 keep,
  input  logic [dalc_pkg::LOAD_W-1:0]   diff,
  output logic [SUM_W-1:0]              top_sum
);
  import dalc_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [LOAD_W-1:0] list_r [DEPTH];
  logic [LOAD_W-1:0] list_nxt [DEPTH];
  logic [SUM_W-1:0]  sum_r;
  logic [KW-1:0]     keep_m1;
  logic [LOAD_W-1:0] tail;
  logic              take;

  always_comb begin
    keep_m1 = keep - 1'b1;
    tail = list_r[keep_m1[IW-1:0]];
    take = ctl.insert && (keep != '0) && (diff > tail);
    for (int j = 0; j < DEPTH; j++) begin
      list_nxt[j] = list_r[j];
      if (32'(j) < 32'(keep)) begin
        if (list_r[j] < diff) begin
          if (j == 0) begin
            list_nxt[j] = diff;
          end else if (list_r[(j > 0) ? j - 1 : 0] >= diff) begin
            list_nxt[j] = diff;
          end else begin
            list_nxt[j] = list_r[(j > 0) ? j - 1 : 0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      sum_r <= '0;
      for (int j = 0; j < DEPTH; j++) begin
        list_r[j] <= '0;
      end
    end else if (take) begin
      sum_r <= sum_r + SUM_W'(diff) - SUM_W'(tail);
      for (int j = 0; j < DEPTH; j++) begin
        list_r[j] <= list_nxt[j];
      end
    end
  end

  assign top_sum = sum_r;

endmodule

// ===== rtl/core/da_lc_response_bound.sv =====
// Top level of the DA-LC response bound block with its sequencer and task store.
// Usage: tasks arrive on the in_ channel, one transfer per task, with period,
// WCET and priority; the transfer with last_task set closes the set and starts
// the analysis. While the analysis runs in_stall stays high. One result per
// stored task leaves on the out_ channel in load order; last_result marks the
// final one, after which the set is empty and in_stall drops again.
// A non-final task is accepted whenever the block is idle. The analysis runs
// every interference term through one shared bit-serial divider, whose
// dividend width DW is 22 at 16 tasks. Each higher-priority pair costs two
// divisions, every other pair needs none, and each task adds its fetch, the
// division by the core count and its result.
// The num_cores register is written over the cfg_ channel while the block is
// idle; it resets to 8. A synchronous reset empties the set and drops out_valid.
// A result waits in the output register while out_stall is high, and the
// sequencer holds the next result until that register is free.
module da_lc_response_bound #(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned MAX_CORES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dalc_pkg::dalc_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dalc_pkg::dalc_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dalc_pkg::CFG_W-1:0]           cfg_data
);
  import dalc_pkg::*;

  localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_TASKS + 1);
  localparam int unsigned CW = $clog2(MAX_CORES + 1);
  localparam int unsigned TOP_DEPTH = (MAX_CORES > 1) ? MAX_CORES - 1 : 1;
  localparam int unsigned SUM_W = LOAD_W + $clog2(MAX_TASKS);
  localparam int unsigned DW = SUM_W + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_K, S_LD_K, S_RD_I, S_LD_I, S_DIV_D, S_MUL_D, S_ADD_D,
    S_DIV_NC, S_MUL_NC, S_ADD_NC, S_NEXT_I, S_DIV_M, S_EMIT
  } state_t;

  state_t              state_r;
  dalc_task_t          mem [MAX_TASKS];
  dalc_task_t          rd_r;
  logic [AW-1:0]       rd_addr;
  logic [CNTW-1:0]     count_r;
  logic [CNTW-1:0]     k_r;
  logic [CNTW-1:0]     i_r;
  logic [CFG_W-1:0]    cores_r;
  logic [CW-1:0]       m_r;
  logic [PERIOD_W-1:0] tk_r, ck_r, ti_r, ci_r;
  logic [PRI_W-1:0]    pk_r;
  logic [LOAD_W-1:0]   cap_r;
  logic [LOAD_W-1:0]   id_r;
  logic [LOAD_W:0]     prod_r;
  logic [PERIOD_W-1:0] remmin_r;
  logic [SUM_W-1:0]    nc_sum_r;
  dalc_out_t           res_r;
  dalc_out_t           out_r;
  logic                out_valid_r;
  logic                out_load;

  logic [PERIOD_W-1:0] in_t, in_c;
  logic [31:0]         m_sel;
  logic [LOAD_W:0]     wl;
  logic [LOAD_W-1:0]   wl_cap;
  logic [LOAD_W-1:0]   span;
  logic [32:0]         prod_full;
  logic [31:0]         bound32;
  logic [SUM_W-1:0]    top_sum;
  dalc_list_ctl_t      list_ctl;
  logic [CW-1:0]       keep;

  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [PERIOD_W-1:0] div_divisor;
  logic                div_busy;
  logic                div_done;
  logic [DW-1:0]       div_quo;
  logic [PERIOD_W-1:0] div_rem;

  always_comb begin
    in_t = (in_data.period == '0) ? PERIOD_W'(1) : in_data.period;
    in_c = (in_data.wcet > in_t) ? in_t : in_data.wcet;
    m_sel = (cores_r == '0) ? 32'd1 : 32'(cores_r);
    if (m_sel > MAX_CORES) begin
      m_sel = MAX_CORES;
    end
    span = {1'b0, tk_r} + {1'b0, rd_r.period} - {1'b0, rd_r.wcet};
    prod_full = 33'(div_quo[LOAD_W-1:0]) * 33'(ci_r);
    wl = prod_r + (LOAD_W + 1)'(remmin_r);
    wl_cap = (wl < (LOAD_W + 1)'(cap_r)) ? wl[LOAD_W-1:0] : cap_r;
    bound32 = 32'(ck_r) + 32'(div_quo);
    keep = m_r - 1'b1;
    out_load = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
    rd_addr = (state_r == S_RD_K) ? k_r[AW-1:0] : i_r[AW-1:0];
    list_ctl.clear = (state_r == S_LD_K);
    list_ctl.insert = (state_r == S_ADD_NC);
    div_start = 1'b0;
    div_dividend = '0;
    div_divisor = ti_r;
    unique case (state_r)
      S_LD_I: begin
        div_start = rd_r.prio > pk_r;
        div_dividend = DW'(span);
        div_divisor = rd_r.period;
      end
      S_ADD_D: begin
        div_start = 1'b1;
        div_dividend = DW'(tk_r);
      end
      S_NEXT_I: begin
        div_start = (i_r == count_r - 1'b1);
        div_dividend = DW'(nc_sum_r) + DW'(top_sum);
        div_divisor = PERIOD_W'(m_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid && count_r < CNTW'(MAX_TASKS)) begin
      mem[count_r[AW-1:0]] <= '{period: in_t, wcet: in_c, prio: in_data.priority_req};
    end
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cores_r <= CORES_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cores_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_r <= res_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (count_r < CNTW'(MAX_TASKS)) begin
              count_r <= count_r + 1'b1;
            end
            m_r <= CW'(m_sel);
            k_r <= '0;
            if (in_data.last_task && (count_r != '0 || MAX_TASKS > 0)) begin
              state_r <= S_RD_K;
            end
          end
        end
        S_RD_K: state_r <= S_LD_K;
        S_LD_K: begin
          tk_r <= rd_r.period;
          ck_r <= rd_r.wcet;
          pk_r <= rd_r.prio;
          cap_r <= {1'b0, rd_r.period} - {1'b0, rd_r.wcet} + 1'b1;
          nc_sum_r <= '0;
          i_r <= '0;
          state_r <= S_RD_I;
        end
        S_RD_I: state_r <= S_LD_I;
        S_LD_I: begin
          ti_r <= rd_r.period;
          ci_r <= rd_r.wcet;
          state_r <= (rd_r.prio > pk_r) ? S_DIV_D : S_NEXT_I;
        end
        S_DIV_D: if (div_done) state_r <= S_MUL_D;
        S_MUL_D: begin
          prod_r <= prod_full[LOAD_W:0];
          remmin_r <= (div_rem < ci_r) ? div_rem : ci_r;
          state_r <= S_ADD_D;
        end
        S_ADD_D: begin
          id_r <= wl_cap;
          state_r <= S_DIV_NC;
        end
        S_DIV_NC: if (div_done) state_r <= S_MUL_NC;
        S_MUL_NC: begin
          prod_r <= prod_full[LOAD_W:0];
          remmin_r <= (div_rem < ci_r) ? div_rem : ci_r;
          state_r <= S_ADD_NC;
        end
        S_ADD_NC: begin
          nc_sum_r <= nc_sum_r + SUM_W'(wl_cap);
          state_r <= S_NEXT_I;
        end
        S_NEXT_I: begin
          if (i_r == count_r - 1'b1) begin
            state_r <= S_DIV_M;
          end else begin
            i_r <= i_r + 1'b1;
            state_r <= S_RD_I;
          end
        end
        S_DIV_M: begin
          if (div_done) begin
            res_r.task_index <= IDX_W'(k_r);
            res_r.response_bound <= (bound32 > 32'(BOUND_MAX)) ? BOUND_MAX :
                                    BOUND_W'(bound32);
            res_r.meets_deadline <= bound32 <= 32'(tk_r);
            res_r.last_result <= (k_r == count_r - 1'b1);
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load) begin
            if (k_r == count_r - 1'b1) begin
              count_r <= '0;
              state_r <= S_IDLE;
            end else begin
              k_r <= k_r + 1'b1;
              state_r <= S_RD_K;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  dalc_div #(
    .DW(DW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  dalc_toplist #(
    .DEPTH (TOP_DEPTH),
    .KW    (CW),
    .SUM_W (SUM_W)
  ) u_toplist (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (list_ctl),
    .keep    (keep),
    .diff    (id_r - wl_cap),
    .top_sum (top_sum)
  );

  assign in_stall = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_busy_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV_D || state_r == S_DIV_NC || state_r == S_DIV_M))
    else $error("Divider runs outside a divide state.");

  a_work_has_tasks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (count_r != '0))
    else $error("Analysis runs on an empty task set.");

  a_last_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_r.last_result) |=> (state_r == S_IDLE && count_r == '0))
    else $error("Set not cleared after its final result.");
`endif

endmodule

// ===== tb/da_lc_response_bound_tb.sv =====
// Self-checking testbench for the DA-LC response bound block: random task sets and core counts.
module da_lc_response_bound_tb;
  import dalc_pkg::*;

  localparam int unsigned N_TASKS = 16;
  localparam int unsigned N_CORES = 16;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  dalc_in_t in_data;
  logic out_valid;
  logic out_stall;
  dalc_out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  da_lc_response_bound #(.MAX_TASKS(N_TASKS), .MAX_CORES(N_CORES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  dalc_in_t task_queue[$];
  dalc_out_t bound_queue[$];
  int errors = 0;
  int items_sent = 0;
  bit quiet = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int tx_gap = 0;
  int rx_cnt = 0;

  logic [PERIOD_W-1:0] set_period[N_TASKS];
  logic [PERIOD_W-1:0] set_wcet[N_TASKS];
  logic [PRI_W-1:0] set_prio[N_TASKS];
  int set_count = 0;
  logic [CFG_W-1:0] cores_reg = CORES_RESET;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic predict_bounds(input dalc_in_t it);
    longint t, c, tk, ck, cap, ti, ci, span, n, wd, wnc, diff, nc_sum, total, bound;
    longint top[N_CORES];
    int m, keep, filled, j;
    dalc_out_t r;
    t = it.period;
    if (t == 0) t = 1;
    c = it.wcet;
    if (c > t) c = t;
    if (set_count < N_TASKS) begin
      set_period[set_count] = t;
      set_wcet[set_count] = c;
      set_prio[set_count] = it.priority_req;
      set_count++;
    end
    if (!it.last_task) return;
    m = cores_reg;
    if (m == 0) m = 1;
    if (m > N_CORES) m = N_CORES;
    keep = m - 1;
    for (int k = 0; k < set_count; k++) begin
      tk = set_period[k];
      ck = set_wcet[k];
      cap = tk - ck + 1;
      nc_sum = 0;
      filled = 0;
      for (int q = 0; q < N_CORES; q++) top[q] = 0;
      for (int i = 0; i < set_count; i++) begin
        if (set_prio[i] <= set_prio[k]) continue;
        ti = set_period[i];
        ci = set_wcet[i];
        span = tk + ti - ci;
        n = span / ti;
        wd = n * ci + ((ci < span - n * ti) ? ci : span - n * ti);
        n = tk / ti;
        wnc = n * ci + ((ci < tk - n * ti) ? ci : tk - n * ti);
        if (wd > cap) wd = cap;
        if (wnc > cap) wnc = cap;
        nc_sum += wnc;
        diff = wd - wnc;
        if (keep == 0) continue;
        if (filled < keep) begin
          j = filled;
          filled++;
        end else if (diff > top[keep-1]) begin
          j = keep - 1;
        end else begin
          continue;
        end
        while (j > 0 && top[j-1] < diff) begin
          top[j] = top[j-1];
          j--;
        end
        top[j] = diff;
      end
      total = nc_sum;
      for (int q = 0; q < filled; q++) total += top[q];
      if (total < 0) total = 0;
      bound = ck + total / m;
      if (bound > BOUND_MAX) bound = BOUND_MAX;
      r.task_index = k[IDX_W-1:0];
      r.response_bound = bound[BOUND_W-1:0];
      r.meets_deadline = (bound <= tk);
      r.last_result = (k + 1 == set_count);
      bound_queue.insert(bound_queue.size(), r);
    end
    set_count = 0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      tx_gap <= 0;
    end else begin
      if (in_valid && !in_stall) predict_bounds(in_data);
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap <= tx_gap - 1;
          in_valid <= 1'b0;
        end else if (task_queue.size() > 0) begin
          in_data <= task_queue.pop_front();
          in_valid <= 1'b1;
          tx_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_cnt <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      out_stall <= 1'b1;
      rx_cnt <= 3000;
    end else if (rx_cnt > 0) begin
      rx_cnt <= rx_cnt - 1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 30);
      rx_cnt <= ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    dalc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bound_queue.size() == 0) begin
        report($sformatf("unexpected result %p", out_data));
      end else begin
        want = bound_queue.pop_front();
        if (out_data.task_index !== want.task_index)
          report($sformatf("task_index %0d, want %0d", out_data.task_index, want.task_index));
        if (out_data.response_bound !== want.response_bound)
          report($sformatf("response_bound %0d, want %0d (task %0d)",
                           out_data.response_bound, want.response_bound, want.task_index));
        if (out_data.meets_deadline !== want.meets_deadline)
          report($sformatf("meets_deadline %0b, want %0b (task %0d)",
                           out_data.meets_deadline, want.meets_deadline, want.task_index));
        if (out_data.last_result !== want.last_result)
          report($sformatf("last_result %0b, want %0b (task %0d)",
                           out_data.last_result, want.last_result, want.task_index));
      end
    end
  end

  task automatic push_task(input int t, input int c, input int p, input bit last);
    dalc_in_t it;
    it.period = t[PERIOD_W-1:0];
    it.wcet = c[PERIOD_W-1:0];
    it.priority_req = p[PRI_W-1:0];
    it.last_task = last;
    task_queue.insert(task_queue.size(), it);
    items_sent++;
  endtask

  task automatic wait_idle();
    while (task_queue.size() > 0 || in_valid || bound_queue.size() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_cores(input int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v[CFG_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cores_reg = v[CFG_W-1:0];
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_set(input int n);
    int t, c, p;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: t = $urandom_range(0, 65535);
        1: t = $urandom_range(1, 20);
        default: t = $urandom_range(10, 500);
      endcase
      case ($urandom_range(0, 3))
        0: c = $urandom_range(0, 65535);
        1: c = (t > 1) ? $urandom_range(1, t) : 1;
        default: c = (t > 4) ? $urandom_range(1, t / 4) : 1;
      endcase
      p = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 7) : $urandom_range(0, 255);
      push_task(t, c, p, i == n - 1);
    end
  endtask

  initial begin
    int core_opts[8] = '{0, 1, 2, 3, 8, 16, 17, 31};
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    quiet = 1;
    push_task(100, 10, 0, 1);
    push_task(0, 0, 255, 0);
    push_task(65535, 65535, 0, 0);
    push_task(10, 65535, 0, 0);
    push_task(1, 1, 255, 0);
    push_task(65535, 1, 128, 1);
    wait_idle();
    quiet = 0;
    write_cores(1);
    push_task(7, 3, 5, 0);
    push_task(7, 3, 5, 0);
    push_task(20, 4, 9, 0);
    push_task(30, 30, 0, 1);
    wait_idle();
    write_cores(16);
    for (int i = 0; i < 18; i++) push_task(13 + 7 * i, 2 + i, i * 15, i == 17);
    wait_idle();
    write_cores(31);
    random_set(16);
    wait_idle();
    write_cores(0);
    random_set(3);
    wait_idle();

    write_cores(4);
    hold_req = hold_req + 1;
    random_set(4);
    random_set(3);
    random_set(2);
    wait_idle();

    while (items_sent < 260) begin
      write_cores(core_opts[$urandom_range(0, 7)]);
      quiet = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 4)) random_set(($urandom_range(0, 9) == 0) ?
                                              $urandom_range(7, 17) : $urandom_range(1, 6));
      wait_idle();
    end
    write_cores(8);
    random_set(5);
    wait_idle();
    repeat (200) @(negedge clk);
    if (bound_queue.size() != 0) report("results still outstanding at end");
    if (errors == 0) begin
      $display("da_lc_response_bound verification clean");
    end else begin
      $display("da_lc_response_bound verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("da_lc_response_bound verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/dalc_pkg.sv
rtl/core/dalc_div.sv
rtl/core/dalc_toplist.sv
rtl/core/da_lc_response_bound.sv
tb/da_lc_response_bound_tb.sv
